// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_front, pps_back and preemptive_priority_scheduler_top.
// Depends on nothing.
`default_nettype none

package pps_pkg;

   localparam int MAX_PROCS   = 16;
   localparam int IDX_W       = $clog2(MAX_PROCS);
   localparam int CNT_W       = $clog2(MAX_PROCS + 1);
   localparam int TIME_W      = 24;
   localparam int ARR_W       = 16;
   localparam int BURST_W     = 16;
   localparam int LVL_W       = 8;
   localparam int PID_W       = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [ARR_W-1:0]     arrival;
      logic [BURST_W-1:0]   burst;
      logic [LVL_W-1:0]     level;
   } item_type;

   typedef struct packed {
      logic                 idle;
      logic [PID_W-1:0]     proc_num;
      logic                 switched;
      logic [TIME_W-1:0]    start_time;
      logic                 finished;
      logic [TIME_W-1:0]    exit_stamp;
      logic [TIME_W-1:0]    turnaround;
      logic [TIME_W-1:0]    waiting;
      logic                 all_done;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pps_front.sv =====
// Front end of the scheduler: accepts request words, classifies them as
// load or tick, and holds them in a short queue for the back end.
// Depends on pps_pkg.
`default_nettype none

module pps_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [pps_pkg::ARR_W-1:0]     req_arrival_time,
   input  wire logic [pps_pkg::BURST_W-1:0]   req_burst_time,
   input  wire logic [pps_pkg::LVL_W-1:0]     req_priority_level,
   output logic                               q_valid,
   output pps_pkg::item_type                  q_item,
   input  wire logic                          q_pop
);

   pps_pkg::item_type                  slot_ff [pps_pkg::QUEUE_DEPTH];
   logic [pps_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [pps_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [pps_pkg::QCNT_W-1:0]         count_ff, count_in;
   pps_pkg::item_type                  item_in;
   logic                               push;
   logic                               pop;

   always_comb begin
      item_in.kind    = req_mode ? pps_pkg::KIND_TICK : pps_pkg::KIND_LOAD;
      item_in.arrival = req_arrival_time;
      item_in.burst   = req_burst_time;
      item_in.level   = req_priority_level;
   end

   assign req_stall = (count_ff == pps_pkg::QCNT_W'(pps_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pps_pkg::QPTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + pps_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pps_pkg::QPTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + pps_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + pps_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pps_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pps_back.sv =====
// Back end of the scheduler: process table, sequential priority scan with
// one comparator, state update and the registered result word.
// Depends on pps_pkg.
`default_nettype none

module pps_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire pps_pkg::item_type    q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output pps_pkg::result_type       rsp_result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;

   logic [pps_pkg::ARR_W-1:0]          arrival_ff   [pps_pkg::MAX_PROCS];
   logic [pps_pkg::BURST_W-1:0]        burst_ff     [pps_pkg::MAX_PROCS];
   logic [pps_pkg::BURST_W-1:0]        remaining_ff [pps_pkg::MAX_PROCS];
   logic [pps_pkg::LVL_W-1:0]          level_ff     [pps_pkg::MAX_PROCS];
   logic [pps_pkg::MAX_PROCS-1:0]      done_ff, done_in;

   logic [pps_pkg::TIME_W-1:0]         now_ff, now_in;
   logic [pps_pkg::CNT_W-1:0]          loaded_ff, loaded_in;
   logic [pps_pkg::CNT_W-1:0]          finished_cnt_ff, finished_cnt_in;
   logic [pps_pkg::IDX_W-1:0]          last_idx_ff, last_idx_in;
   logic                               last_valid_ff, last_valid_in;

   logic [pps_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                               best_found_ff, best_found_in;
   logic [pps_pkg::IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [pps_pkg::LVL_W-1:0]          best_lvl_ff, best_lvl_in;
   logic [pps_pkg::ARR_W-1:0]          best_arr_ff, best_arr_in;
   logic [pps_pkg::BURST_W-1:0]        best_burst_ff, best_burst_in;
   logic [pps_pkg::BURST_W-1:0]        best_rem_ff, best_rem_in;

   pps_pkg::result_type                pend_ff, pend_in;
   pps_pkg::result_type                res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                               load_we;
   logic [pps_pkg::IDX_W-1:0]          load_slot;
   logic                               rem_we;
   logic [pps_pkg::BURST_W-1:0]        rem_next;
   logic                               eligible;
   logic                               better;
   logic                               scan_last;
   logic                               out_free;
   logic [pps_pkg::TIME_W-1:0]         now_next;
   logic                               fin;

   assign load_slot = loaded_ff[pps_pkg::IDX_W-1:0];
   assign eligible  = !done_ff[idx_ff] &&
                      (pps_pkg::TIME_W'(arrival_ff[idx_ff]) <= now_ff);
   assign better    = !best_found_ff || (level_ff[idx_ff] > best_lvl_ff) ||
                      ((level_ff[idx_ff] == best_lvl_ff) && (arrival_ff[idx_ff] < best_arr_ff));
   assign scan_last = ((pps_pkg::CNT_W'(idx_ff) + pps_pkg::CNT_W'(1)) == loaded_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign now_next  = (now_ff == pps_pkg::TIME_MAX) ? now_ff : now_ff + pps_pkg::TIME_W'(1);
   assign fin       = best_found_ff && (best_rem_ff <= pps_pkg::BURST_W'(1));
   assign rem_next  = fin ? '0 : best_rem_ff - pps_pkg::BURST_W'(1);

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

   always_comb begin
      state_in        = state_ff;
      done_in         = done_ff;
      now_in          = now_ff;
      loaded_in       = loaded_ff;
      finished_cnt_in = finished_cnt_ff;
      last_idx_in     = last_idx_ff;
      last_valid_in   = last_valid_ff;
      idx_in          = idx_ff;
      best_found_in   = best_found_ff;
      best_idx_in     = best_idx_ff;
      best_lvl_in     = best_lvl_ff;
      best_arr_in     = best_arr_ff;
      best_burst_in   = best_burst_ff;
      best_rem_in     = best_rem_ff;
      pend_in         = pend_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      load_we         = 1'b0;
      rem_we          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.kind == pps_pkg::KIND_LOAD) begin
                  if (loaded_ff < pps_pkg::CNT_W'(pps_pkg::MAX_PROCS)) begin
                     load_we            = 1'b1;
                     done_in[load_slot] = 1'b0;
                     loaded_in          = loaded_ff + pps_pkg::CNT_W'(1);
                  end
               end else begin
                  idx_in        = '0;
                  best_found_in = 1'b0;
                  state_in      = (loaded_ff == '0) ? ST_UPDATE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (eligible && better) begin
               best_found_in = 1'b1;
               best_idx_in   = idx_ff;
               best_lvl_in   = level_ff[idx_ff];
               best_arr_in   = arrival_ff[idx_ff];
               best_burst_in = burst_ff[idx_ff];
               best_rem_in   = remaining_ff[idx_ff];
            end
            idx_in = idx_ff + pps_pkg::IDX_W'(1);
            if (scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            now_in             = now_next;
            pend_in.idle       = !best_found_ff;
            pend_in.proc_num   = best_found_ff ?
               pps_pkg::PID_W'(pps_pkg::CNT_W'(best_idx_ff) + pps_pkg::CNT_W'(1)) : '0;
            pend_in.switched   = best_found_ff &&
                                 (!last_valid_ff || (last_idx_ff != best_idx_ff));
            pend_in.start_time = now_ff;
            pend_in.finished   = fin;
            pend_in.exit_stamp = fin ? now_next : '0;
            pend_in.turnaround = fin ? now_next - pps_pkg::TIME_W'(best_arr_ff) : '0;
            pend_in.waiting    = '0;
            pend_in.all_done   = 1'b0;
            if (best_found_ff) begin
               last_idx_in   = best_idx_ff;
               last_valid_in = 1'b1;
               rem_we        = 1'b1;
            end
            if (fin) begin
               done_in[best_idx_ff] = 1'b1;
               finished_cnt_in      = finished_cnt_ff + pps_pkg::CNT_W'(1);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               res_in          = pend_ff;
               res_in.waiting  = (pend_ff.turnaround >= pps_pkg::TIME_W'(best_burst_ff)) ?
                                 pend_ff.turnaround - pps_pkg::TIME_W'(best_burst_ff) : '0;
               if (!pend_ff.finished) begin
                  res_in.waiting = '0;
               end
               res_in.all_done = (finished_cnt_ff >= loaded_ff);
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         done_ff         <= '0;
         now_ff          <= '0;
         loaded_ff       <= '0;
         finished_cnt_ff <= '0;
         last_valid_ff   <= 1'b0;
         best_found_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         done_ff         <= done_in;
         now_ff          <= now_in;
         loaded_ff       <= loaded_in;
         finished_cnt_ff <= finished_cnt_in;
         last_valid_ff   <= last_valid_in;
         best_found_ff   <= best_found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      last_idx_ff   <= last_idx_in;
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_lvl_ff   <= best_lvl_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_rem_ff   <= best_rem_in;
      pend_ff       <= pend_in;
      res_ff        <= res_in;
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         arrival_ff[load_slot]   <= q_item.arrival;
         burst_ff[load_slot]     <= q_item.burst;
         remaining_ff[load_slot] <= q_item.burst;
         level_ff[load_slot]     <= q_item.level;
      end
      if (rem_we) begin
         remaining_ff[best_idx_ff] <= rem_next;
      end
   end

`ifndef SYNTHESIS
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      finished_cnt_ff <= loaded_ff)
      else $error("More processes finished than were loaded.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (pps_pkg::CNT_W'(idx_ff) < loaded_ff))
      else $error("Scan index ran past the loaded slots.");

   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.idle) |-> (!res_ff.finished && !res_ff.switched))
      else $error("Idle result claims a run.");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (now_ff >= $past(now_ff)))
      else $error("Time counter went backward.");
`endif

endmodule

`default_nettype wire

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// Top level of the preemptive priority scheduler.
// Instantiates pps_front and pps_back; depends on pps_pkg.
//
// Request words carry a mode bit: mode 0 loads a process (arrival, burst,
// priority) into the next table slot and gives no response; mode 1 is one
// time tick and gives exactly one response word. Both channels use valid
// and stall; a word moves on a rising edge with valid high and stall low.
// A two-entry queue sits behind the request port, so requests are taken
// while the engine works or a response waits.
// A load is absorbed in the idle step. For a tick, one comparator visits the
// loaded slots (at most 16) one per cycle, then an update step advances
// state and an emit step fills the response register.
// A stalled response holds in its register; the engine then waits in its
// final step and the queue fills until req_stall rises.
// Reset (synchronous, active high) clears time, counts, finished flags and
// the last-run mark; loads fill the process table, ticks count down remaining burst.
`default_nettype none

module preemptive_priority_scheduler_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [pps_pkg::ARR_W-1:0]     req_arrival_time,
   input  wire logic [pps_pkg::BURST_W-1:0]   req_burst_time,
   input  wire logic [pps_pkg::LVL_W-1:0]     req_priority_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_idle,
   output logic [pps_pkg::PID_W-1:0]          rsp_proc_num,
   output logic                               rsp_switched,
   output logic [pps_pkg::TIME_W-1:0]         rsp_start_time,
   output logic                               rsp_finished,
   output logic [pps_pkg::TIME_W-1:0]         rsp_exit_stamp,
   output logic [pps_pkg::TIME_W-1:0]         rsp_turnaround,
   output logic [pps_pkg::TIME_W-1:0]         rsp_waiting,
   output logic                               rsp_all_done
);

   logic                  q_valid;
   pps_pkg::item_type     q_item;
   logic                  q_pop;
   pps_pkg::result_type   result;

   pps_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_arrival_time   (req_arrival_time),
      .req_burst_time     (req_burst_time),
      .req_priority_level (req_priority_level),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   pps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result)
   );

   assign rsp_idle       = result.idle;
   assign rsp_proc_num   = result.proc_num;
   assign rsp_switched   = result.switched;
   assign rsp_start_time = result.start_time;
   assign rsp_finished   = result.finished;
   assign rsp_exit_stamp = result.exit_stamp;
   assign rsp_turnaround = result.turnaround;
   assign rsp_waiting    = result.waiting;
   assign rsp_all_done   = result.all_done;

endmodule

`default_nettype wire

// ===== tb/sv/tb_preemptive_priority_scheduler_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for preemptive_priority_scheduler_top, built on pps_pkg.
// A scoreboard class predicts each tick's scheduling result and compares it with
// the response word. Plain tasks drive loads and ticks with random idling and stalls.

module tb_preemptive_priority_scheduler_top;
   import pps_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_WORDS = 277;

   class gantt_checker;
      logic [TIME_W-1:0]  sched_time;
      logic [ARR_W-1:0]   arrivals  [MAX_PROCS];
      logic [BURST_W-1:0] bursts    [MAX_PROCS];
      logic [BURST_W-1:0] remaining [MAX_PROCS];
      logic [LVL_W-1:0]   levels    [MAX_PROCS];
      bit                 retired   [MAX_PROCS];
      int                 slots_used;
      int                 retired_count;
      int                 last_slot;
      int                 mismatches;
      result_type         gantt_due [$];

      function new();
         sched_time    = '0;
         slots_used    = 0;
         retired_count = 0;
         last_slot     = -1;
         mismatches    = 0;
         foreach (retired[i]) retired[i] = 1'b0;
      endfunction

      function void take_word(item_type w);
         result_type        r;
         int                pick;
         logic [TIME_W-1:0] span;
         if (w.kind == KIND_LOAD) begin
            if (slots_used < MAX_PROCS) begin
               arrivals[slots_used]  = w.arrival;
               bursts[slots_used]    = w.burst;
               remaining[slots_used] = w.burst;
               levels[slots_used]    = w.level;
               retired[slots_used]   = 1'b0;
               slots_used++;
            end
            return;
         end
         pick = -1;
         for (int s = 0; s < slots_used; s++) begin
            if (retired[s] || TIME_W'(arrivals[s]) > sched_time)
               continue;
            if (pick < 0 || levels[s] > levels[pick] ||
                (levels[s] == levels[pick] && arrivals[s] < arrivals[pick]))
               pick = s;
         end
         r = '0;
         r.start_time = sched_time;
         if (sched_time != TIME_MAX)
            sched_time = sched_time + 1'b1;
         if (pick < 0) begin
            r.idle = 1'b1;
         end else begin
            r.proc_num = PID_W'(pick + 1);
            r.switched = (last_slot != pick);
            last_slot  = pick;
            if (remaining[pick] <= 1) begin
               remaining[pick] = '0;
               retired[pick]   = 1'b1;
               retired_count++;
               span         = sched_time - TIME_W'(arrivals[pick]);
               r.finished   = 1'b1;
               r.exit_stamp = sched_time;
               r.turnaround = span;
               r.waiting    = (span >= TIME_W'(bursts[pick])) ?
                              span - TIME_W'(bursts[pick]) : '0;
            end else begin
               remaining[pick] = remaining[pick] - 1'b1;
            end
         end
         r.all_done = (retired_count >= slots_used);
         gantt_due.push_back(r);
      endfunction

      function void compare_field(string field, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_run(result_type got);
         result_type want;
         if (gantt_due.size() == 0) begin
            mismatches++;
            $display("%0t: response expected none, actual proc_num %0d start %0d",
                     $time, got.proc_num, got.start_time);
            return;
         end
         want = gantt_due.pop_front();
         compare_field("idle",       want.idle,       got.idle);
         compare_field("proc_num",   want.proc_num,   got.proc_num);
         compare_field("switched",   want.switched,   got.switched);
         compare_field("start_time", want.start_time, got.start_time);
         compare_field("finished",   want.finished,   got.finished);
         compare_field("exit_stamp", want.exit_stamp, got.exit_stamp);
         compare_field("turnaround", want.turnaround, got.turnaround);
         compare_field("waiting",    want.waiting,    got.waiting);
         compare_field("all_done",   want.all_done,   got.all_done);
      endfunction
   endclass

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_mode           = 1'b0;
   logic [ARR_W-1:0]   req_arrival_time   = '0;
   logic [BURST_W-1:0] req_burst_time     = '0;
   logic [LVL_W-1:0]   req_priority_level = '0;
   logic               rsp_stall          = 1'b0;
   wire                req_stall;
   wire                rsp_valid;
   wire                rsp_idle;
   wire [PID_W-1:0]    rsp_proc_num;
   wire                rsp_switched;
   wire [TIME_W-1:0]   rsp_start_time;
   wire                rsp_finished;
   wire [TIME_W-1:0]   rsp_exit_stamp;
   wire [TIME_W-1:0]   rsp_turnaround;
   wire [TIME_W-1:0]   rsp_waiting;
   wire                rsp_all_done;

   int                 send_idle_pct  = 38;
   int                 recv_stall_pct = 55;
   int                 quiet_cycles   = 0;
   logic [ARR_W-1:0]   last_arrival   = '0;
   logic [LVL_W-1:0]   last_level     = '0;
   gantt_checker       ledger         = new();

   preemptive_priority_scheduler_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_arrival_time   (req_arrival_time),
      .req_burst_time     (req_burst_time),
      .req_priority_level (req_priority_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_idle           (rsp_idle),
      .rsp_proc_num       (rsp_proc_num),
      .rsp_switched       (rsp_switched),
      .rsp_start_time     (rsp_start_time),
      .rsp_finished       (rsp_finished),
      .rsp_exit_stamp     (rsp_exit_stamp),
      .rsp_turnaround     (rsp_turnaround),
      .rsp_waiting        (rsp_waiting),
      .rsp_all_done       (rsp_all_done)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic offer_word(input item_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= w.kind;
      req_arrival_time   <= w.arrival;
      req_burst_time     <= w.burst;
      req_priority_level <= w.level;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      ledger.take_word(w);
   endtask

   task automatic send_load(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                            input logic [LVL_W-1:0] lvl);
      offer_word(item_type'{KIND_LOAD, arr, burst, lvl});
   endtask

   task automatic send_tick();
      offer_word(item_type'{KIND_TICK, ARR_W'($urandom), BURST_W'($urandom),
                            LVL_W'($urandom)});
   endtask

   task automatic send_random_load();
      int               reach;
      logic [ARR_W-1:0] arr;
      logic [LVL_W-1:0] lvl;
      logic [BURST_W-1:0] burst;
      reach = int'(ledger.sched_time);
      case ($urandom_range(0, 3))
         0: arr = last_arrival;
         1: arr = (reach > 20) ? ARR_W'(reach - $urandom_range(0, 20)) : '0;
         default: arr = ARR_W'(reach + $urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 7))
         0, 1: lvl = last_level;
         2: lvl = '0;
         3: lvl = '1;
         default: lvl = LVL_W'($urandom);
      endcase
      burst = ($urandom_range(0, 7) == 0) ? BURST_W'(1) : BURST_W'($urandom_range(1, 80));
      last_arrival = arr;
      last_level   = lvl;
      send_load(arr, burst, lvl);
   endtask

   // One slot is kept free for the never-eligible process loaded at the end.
   task automatic random_stretch(input int words);
      int sent;
      int next_load_at;
      int batch;
      sent         = 0;
      next_load_at = $urandom_range(0, 40);
      while (sent < words) begin
         if (ledger.slots_used < MAX_PROCS - 1 && sent >= next_load_at) begin
            batch = ($urandom_range(0, 9) < 7) ? 1 : 2;
            repeat (batch) begin
               if (ledger.slots_used < MAX_PROCS - 1) begin
                  send_random_load();
                  sent++;
               end
            end
            next_load_at = sent + $urandom_range(70, 130);
         end else begin
            send_tick();
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         ledger.check_run(result_type'{rsp_idle, rsp_proc_num, rsp_switched,
                                       rsp_start_time, rsp_finished, rsp_exit_stamp,
                                       rsp_turnaround, rsp_waiting, rsp_all_done});
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall == 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_preemptive_priority_scheduler_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty table, zero burst, ties on level and arrival, preemption.
      send_tick();
      send_load(16'd0, 16'd3, 8'd0);
      send_tick();
      send_load(16'd5, 16'd1, 8'd255);
      send_load(16'd2, 16'd0, 8'd10);
      repeat (5) send_tick();
      send_load(16'd8, 16'd2, 8'd7);
      send_load(16'd8, 16'd1, 8'd7);
      repeat (4) send_tick();
      send_load(16'd11, 16'd3, 8'd3);
      send_load(16'd9, 16'd2, 8'd3);
      send_load(16'd12, 16'd2, 8'd200);
      repeat (5) send_tick();

      random_stretch(PHASE_WORDS);
      send_idle_pct  = 55;
      recv_stall_pct = 38;
      random_stretch(PHASE_WORDS);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_stretch(PHASE_WORDS);

      // Fill the table, then show that further loads are dropped.
      while (ledger.slots_used < MAX_PROCS - 1)
         send_load(16'hFFFF, BURST_W'($urandom_range(1, 65535)), LVL_W'($urandom));
      send_load(16'hFFFF, 16'hFFFF, 8'hFF);
      repeat (3)
         send_load(16'd0, BURST_W'($urandom_range(1, 65535)), LVL_W'($urandom));
      repeat (4) send_tick();
      req_valid <= 1'b0;

      while (ledger.gantt_due.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.gantt_due.size() == 0) begin
         $display("tb_preemptive_priority_scheduler_top: done, clean");
      end else begin
         $display("tb_preemptive_priority_scheduler_top: done, errors");
      end
      $finish;
   end

endmodule
